// ===== rtl/uv_pkg.sv =====
// Shared types and byte constants for the UTF-8 stream validator.
// No dependencies; imported by the top level, uv_check and uv_checker (uv_skid does not use it).
package uv_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int ERR_OFFSET_W     = 32;

  localparam logic [7:0] BYTE_TERM    = 8'h00;
  localparam logic [7:0] BYTE_ASCII   = 8'h80;
  localparam logic [7:0] MASK_TOP3    = 8'he0;
  localparam logic [7:0] MASK_TOP2    = 8'hc0;
  localparam logic [7:0] MASK_TOP4    = 8'hf0;
  localparam logic [7:0] MASK_TOP5    = 8'hf8;
  localparam logic [7:0] MASK_TOP7    = 8'hfe;
  localparam logic [7:0] LEAD_2       = 8'hc0;
  localparam logic [7:0] LEAD_3       = 8'he0;
  localparam logic [7:0] LEAD_4       = 8'hf0;
  localparam logic [7:0] LEAD_4_MAX   = 8'hf4;
  localparam logic [7:0] LEAD_SURR    = 8'hed;
  localparam logic [7:0] LEAD_NONCHAR = 8'hef;
  localparam logic [7:0] CONT_BASE    = 8'h80;
  localparam logic [7:0] CONT_SURR    = 8'ha0;
  localparam logic [7:0] CONT_MAX_F4  = 8'h8f;
  localparam logic [7:0] CONT_TOP     = 8'hbf;
  localparam logic [7:0] CONT_NONCHAR = 8'hbe;

  localparam logic [1:0] SEQ_SECOND = 2'd0;
  localparam logic [1:0] SEQ_THIRD  = 2'd1;

  typedef struct packed {
    logic                    string_valid;
    logic [ERR_OFFSET_W-1:0] error_offset;
  } res_t;

endpackage

// ===== rtl/utf8_stream_validator.sv =====
// Top level of the UTF-8 stream validator: input skid, byte check, result skid.
// Depends on uv_pkg, uv_skid and uv_check.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------
//   in      | in_valid/in_ready   | text_byte[7:0]
//   out     | out_valid/out_ready | string_valid, error_offset[31:0]
//
// One beat per cycle while out is not stalled; a byte's result, if any, is registered
// in the input skid and then in the result skid before it shows on out.
// Reset clears the sequence state and both skid stages; in_ready is high after.
// A stalled out holds its beat; a second skid entry on each side keeps in
// flowing one more beat before in_ready drops.
module utf8_stream_validator
  import uv_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              text_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    string_valid,
  output logic [ERR_OFFSET_W-1:0] error_offset
);

  logic       chk_valid;
  logic       chk_ready;
  logic [7:0] chk_byte;
  logic       res_valid;
  logic       res_ready;
  res_t       res;
  res_t       res_out;

  uv_skid #(.W(8)) u_in_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (text_byte),
    .dn_valid (chk_valid),
    .dn_ready (chk_ready),
    .dn_data  (chk_byte)
  );

  uv_check #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_byte   (chk_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  uv_skid #(.W($bits(res_t))) u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (res_valid),
    .up_ready (res_ready),
    .up_data  (res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res_out)
  );

  assign string_valid = res_out.string_valid;
  assign error_offset = res_out.error_offset;

endmodule

// ===== rtl/uv_skid.sv =====
// Two-entry skid register: full-rate valid/ready stage with registered ready.
// Depends on no package; width set by parameter.
module uv_skid #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         main_valid;
  logic [W-1:0] main_data;
  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         up_fire;

  assign up_ready = !skid_valid;
  assign up_fire  = up_valid && up_ready;
  assign dn_valid = main_valid;
  assign dn_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (dn_ready || !main_valid) begin
      main_valid <= skid_valid || up_fire;
      skid_valid <= 1'b0;
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (up_fire) begin
        main_data <= up_data;
      end
    end else if (up_fire) begin
      skid_valid <= 1'b1;
      skid_data  <= up_data;
    end
  end

endmodule

// ===== rtl/uv_check.sv =====
// Per-byte UTF-8 check: sequence state and result decision for one beat.
// Depends on uv_pkg.
module uv_check
  import uv_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  logic [OFFSET_WIDTH-1:0] byte_position, byte_position_next;
  logic [OFFSET_WIDTH-1:0] lead_position, lead_position_next;
  logic [7:0]              lead_byte, lead_byte_next;
  logic [7:0]              second_byte, second_byte_next;
  logic [1:0]              expected, expected_next;
  logic [1:0]              seq_index, seq_index_next;
  logic                    error_reported, error_reported_next;
  logic                    fire;
  logic                    emit;
  logic                    bad;
  logic                    is_term;
  logic [OFFSET_WIDTH-1:0] position_adv;
  logic [1:0]              expected_dec;

  assign in_ready     = res_ready;
  assign fire         = in_valid && res_ready;
  assign res_valid    = fire && emit;
  assign is_term      = in_byte == BYTE_TERM;
  assign position_adv = (&byte_position) ? byte_position
                                         : byte_position + OFFSET_WIDTH'(1);
  assign expected_dec = expected - 2'd1;

  always_comb begin
    byte_position_next  = byte_position;
    lead_position_next  = lead_position;
    lead_byte_next      = lead_byte;
    second_byte_next    = second_byte;
    expected_next       = expected;
    seq_index_next      = seq_index;
    error_reported_next = error_reported;
    emit                = 1'b0;
    bad                 = 1'b0;
    res.string_valid    = 1'b0;
    res.error_offset    = ERR_OFFSET_W'(lead_position);

    if (error_reported) begin
      if (is_term) begin
        byte_position_next  = '0;
        lead_position_next  = '0;
        expected_next       = 2'd0;
        seq_index_next      = 2'd0;
        error_reported_next = 1'b0;
      end
    end else if (expected == 2'd0) begin
      if (is_term) begin
        byte_position_next  = '0;
        lead_position_next  = '0;
        seq_index_next      = 2'd0;
        emit                = 1'b1;
        res.string_valid    = 1'b1;
        res.error_offset    = '0;
      end else begin
        lead_position_next = byte_position;
        lead_byte_next     = in_byte;
        seq_index_next     = 2'd0;
        if (in_byte < BYTE_ASCII) begin
          expected_next = 2'd0;
        end else if ((in_byte & MASK_TOP3) == LEAD_2) begin
          if ((in_byte & MASK_TOP7) == LEAD_2) begin
            bad = 1'b1;
          end else begin
            expected_next = 2'd1;
          end
        end else if ((in_byte & MASK_TOP4) == LEAD_3) begin
          expected_next = 2'd2;
        end else if ((in_byte & MASK_TOP5) == LEAD_4) begin
          if (in_byte > LEAD_4_MAX) begin
            bad = 1'b1;
          end else begin
            expected_next = 2'd3;
          end
        end else begin
          bad = 1'b1;
        end
        if (bad) begin
          error_reported_next = 1'b1;
          expected_next       = 2'd0;
          emit                = 1'b1;
          res.error_offset    = ERR_OFFSET_W'(byte_position);
        end else begin
          byte_position_next = position_adv;
        end
      end
    end else begin
      if ((in_byte & MASK_TOP2) != CONT_BASE) begin
        bad = 1'b1;
      end
      if (seq_index == SEQ_SECOND) begin
        if (lead_byte == LEAD_3 && (in_byte & MASK_TOP3) == CONT_BASE) bad = 1'b1;
        if (lead_byte == LEAD_SURR && (in_byte & MASK_TOP3) == CONT_SURR) bad = 1'b1;
        if (lead_byte == LEAD_4 && (in_byte & MASK_TOP4) == CONT_BASE) bad = 1'b1;
        if (lead_byte == LEAD_4_MAX && in_byte > CONT_MAX_F4) bad = 1'b1;
        second_byte_next = in_byte;
      end else if (seq_index == SEQ_THIRD) begin
        if (lead_byte == LEAD_NONCHAR && second_byte == CONT_TOP &&
            (in_byte & MASK_TOP7) == CONT_NONCHAR) begin
          bad = 1'b1;
        end
      end
      if (bad) begin
        emit = 1'b1;
        if (is_term) begin
          byte_position_next  = '0;
          lead_position_next  = '0;
          expected_next       = 2'd0;
          seq_index_next      = 2'd0;
          error_reported_next = 1'b0;
        end else begin
          error_reported_next = 1'b1;
          expected_next       = 2'd0;
          seq_index_next      = 2'd0;
        end
      end else begin
        expected_next      = expected_dec;
        seq_index_next     = (expected_dec == 2'd0) ? 2'd0 : seq_index + 2'd1;
        byte_position_next = position_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      lead_position  <= '0;
      lead_byte      <= '0;
      second_byte    <= '0;
      expected       <= 2'd0;
      seq_index      <= 2'd0;
      error_reported <= 1'b0;
    end else if (fire) begin
      byte_position  <= byte_position_next;
      lead_position  <= lead_position_next;
      lead_byte      <= lead_byte_next;
      second_byte    <= second_byte_next;
      expected       <= expected_next;
      seq_index      <= seq_index_next;
      error_reported <= error_reported_next;
    end
  end

endmodule

// ===== rtl/uv_checker.sv =====
// Port-level assertions for utf8_stream_validator, bound to the top level.
// Depends on uv_pkg.
module uv_checker
  import uv_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [7:0]              text_byte,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    string_valid,
  input logic [ERR_OFFSET_W-1:0] error_offset
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(text_byte))
    else $error("in beat changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(string_valid) && $stable(error_offset))
    else $error("out beat changed while stalled");

  a_valid_zero_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_valid |-> error_offset == '0)
    else $error("valid result with nonzero offset");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out beat present after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("in not ready after reset");

endmodule

bind utf8_stream_validator uv_checker u_uv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .text_byte    (text_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .string_valid (string_valid),
  .error_offset (error_offset)
);

// ===== verif/tb_utf8_stream_validator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_validator: directed strings, then random
// strings of valid and corrupted UTF-8, checked against an in-bench string checker.
// Depends on uv_pkg and the utf8_stream_validator RTL.
module tb_utf8_stream_validator;
  import uv_pkg::*;

  localparam int DIRECTED_LEN = 28;
  localparam int RANDOM_ITEMS = 650;
  localparam int GAP_MAX      = 11;
  localparam int TAIL_CYCLES  = 16;

  // empty, ascii and two-byte, bad leads, stray continuation, overlong,
  // surrogate, above 10FFFF, noncharacter, cut short by the terminator, a lone ASCII byte
  localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
    8'h00,
    8'h7f, 8'hc2, 8'h80, 8'h00,
    8'hc1, 8'h00,
    8'hf5, 8'h00,
    8'h80, 8'h00,
    8'he0, 8'h80, 8'h00,
    8'hed, 8'ha0, 8'h00,
    8'hf4, 8'h90, 8'h00,
    8'hef, 8'hbf, 8'hbe, 8'h00,
    8'he2, 8'h82, 8'h00,
    8'h41
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              text_byte = 8'h00;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    string_valid;
  logic [ERR_OFFSET_W-1:0] error_offset;

  utf8_stream_validator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .string_valid (string_valid),
    .error_offset (error_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] pending_bytes[$];
  logic [7:0] draft[$];
  int         pause_points[$];
  res_t       string_verdicts[$];
  int         issued = 0;
  int         checked = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         failures = 0;

  // string checker state
  logic [ERR_OFFSET_W-1:0] cur_pos;
  logic [ERR_OFFSET_W-1:0] seq_start;
  logic [7:0]              seq_lead;
  logic [7:0]              seq_second;
  logic [1:0]              cont_left;
  logic [1:0]              cont_seen;
  logic                    skipping;

  function automatic void restart_string();
    cur_pos   = '0;
    seq_start = '0;
    cont_left = 2'd0;
    cont_seen = 2'd0;
    skipping  = 1'b0;
  endfunction

  function automatic void push_verdict(input logic ok, input logic [ERR_OFFSET_W-1:0] off);
    res_t r;
    r.string_valid = ok;
    r.error_offset = ok ? '0 : off;
    string_verdicts.push_back(r);
  endfunction

  function automatic void bump_position();
    if (cur_pos != '1) cur_pos = cur_pos + ERR_OFFSET_W'(1);
  endfunction

  function automatic void check_byte(input logic [7:0] b);
    logic bad;
    bad = 1'b0;
    if (skipping) begin
      if (b == BYTE_TERM) restart_string();
    end else if (cont_left == 2'd0) begin
      if (b == BYTE_TERM) begin
        restart_string();
        push_verdict(1'b1, '0);
      end else begin
        seq_start = cur_pos;
        seq_lead  = b;
        cont_seen = 2'd0;
        if (b < BYTE_ASCII) begin
        end else if ((b & MASK_TOP3) == LEAD_2) begin
          if ((b & MASK_TOP7) == LEAD_2) bad = 1'b1;
          else cont_left = 2'd1;
        end else if ((b & MASK_TOP4) == LEAD_3) begin
          cont_left = 2'd2;
        end else if ((b & MASK_TOP5) == LEAD_4) begin
          if (b > LEAD_4_MAX) bad = 1'b1;
          else cont_left = 2'd3;
        end else begin
          bad = 1'b1;
        end
        if (bad) begin
          skipping  = 1'b1;
          cont_left = 2'd0;
          push_verdict(1'b0, seq_start);
        end else begin
          bump_position();
        end
      end
    end else begin
      if ((b & MASK_TOP2) != CONT_BASE) bad = 1'b1;
      if (cont_seen == SEQ_SECOND) begin
        if (seq_lead == LEAD_3 && (b & MASK_TOP3) == CONT_BASE) bad = 1'b1;
        if (seq_lead == LEAD_SURR && (b & MASK_TOP3) == CONT_SURR) bad = 1'b1;
        if (seq_lead == LEAD_4 && (b & MASK_TOP4) == CONT_BASE) bad = 1'b1;
        if (seq_lead == LEAD_4_MAX && b > CONT_MAX_F4) bad = 1'b1;
        seq_second = b;
      end else if (cont_seen == SEQ_THIRD) begin
        if (seq_lead == LEAD_NONCHAR && seq_second == CONT_TOP &&
            (b & MASK_TOP7) == CONT_NONCHAR) bad = 1'b1;
      end
      if (bad) begin
        push_verdict(1'b0, seq_start);
        if (b == BYTE_TERM) begin
          restart_string();
        end else begin
          skipping  = 1'b1;
          cont_left = 2'd0;
          cont_seen = 2'd0;
        end
      end else begin
        cont_left = cont_left - 2'd1;
        cont_seen = cont_seen + 2'd1;
        if (cont_left == 2'd0) cont_seen = 2'd0;
        bump_position();
      end
    end
  endfunction

  function automatic logic [7:0] pick(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void append_char();
    logic [7:0] lead;
    logic [7:0] second;
    case ($urandom_range(3, 0))
      0: draft.push_back(pick(8'h01, 8'h7f));
      1: begin
        draft.push_back(pick(8'hc2, 8'hdf));
        draft.push_back(pick(8'h80, 8'hbf));
      end
      2: begin
        lead = pick(8'he0, 8'hef);
        if (lead == LEAD_3) second = pick(8'ha0, 8'hbf);
        else if (lead == LEAD_SURR) second = pick(8'h80, 8'h9f);
        else second = pick(8'h80, 8'hbf);
        draft.push_back(lead);
        draft.push_back(second);
        if (lead == LEAD_NONCHAR && second == CONT_TOP) draft.push_back(pick(8'h80, 8'hbd));
        else draft.push_back(pick(8'h80, 8'hbf));
      end
      default: begin
        lead = pick(8'hf0, 8'hf4);
        if (lead == LEAD_4) second = pick(8'h90, 8'hbf);
        else if (lead == LEAD_4_MAX) second = pick(8'h80, 8'h8f);
        else second = pick(8'h80, 8'hbf);
        draft.push_back(lead);
        draft.push_back(second);
        draft.push_back(pick(8'h80, 8'hbf));
        draft.push_back(pick(8'h80, 8'hbf));
      end
    endcase
  endfunction

  // mostly well-formed strings; some with a damaged byte, some cut short,
  // some pure noise
  function automatic void queue_random_string();
    int kind;
    draft.delete();
    repeat ($urandom_range(8, 0)) append_char();
    kind = $urandom_range(9, 0);
    if (kind == 0) begin
      draft.delete();
      repeat ($urandom_range(8, 1)) draft.push_back(pick(8'h01, 8'hff));
    end else if (kind <= 2 && draft.size() > 0) begin
      draft[$urandom_range(draft.size() - 1, 0)] = pick(8'h01, 8'hff);
    end else if (kind == 3 && draft.size() > 0) begin
      void'(draft.pop_back());
    end
    foreach (draft[i]) pending_bytes.push_back(draft[i]);
    pending_bytes.push_back(BYTE_TERM);
  endfunction

  function automatic int draw_wait(input int count, input int span);
    return ((count / span) % 4 == 1) ? 0 : $urandom_range(GAP_MAX, 0);
  endfunction

  task automatic log_failure(input string what);
    if (failures < 10)
      $display("%0t %s; got valid=%0b offset=%0d", $time, what, string_valid, error_offset);
    failures++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) check_byte(text_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pause_points.size() > 0 && issued == pause_points[0]) begin
          in_valid <= 1'b0;
          if (string_verdicts.size() == 0) void'(pause_points.pop_front());
        end else begin
          in_valid  <= 1'b1;
          text_byte <= pending_bytes.pop_front();
          issued    <= issued + 1;
          gap_left  <= draw_wait(issued, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    int   n;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (string_verdicts.size() == 0) begin
        log_failure("unexpected result");
      end else begin
        want = string_verdicts.pop_front();
        if (string_valid !== want.string_valid || error_offset !== want.error_offset)
          log_failure($sformatf("mismatch, want valid=%0b offset=%0d",
                                want.string_valid, want.error_offset));
      end
      checked <= checked + 1;
      n = draw_wait(checked, 20);
      out_ready  <= (n == 0);
      stall_left <= n;
    end else if (!out_ready) begin
      if (stall_left <= 1) begin
        out_ready  <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  initial begin
    restart_string();
    seq_lead   = 8'h00;
    seq_second = 8'h00;
    foreach (DIRECTED[i]) pending_bytes.push_back(DIRECTED[i]);
    pending_bytes.push_back(BYTE_TERM);
    pause_points.push_back(DIRECTED_LEN + 1);
    pause_points.push_back(DIRECTED_LEN + 320);
    while (pending_bytes.size() < RANDOM_ITEMS) queue_random_string();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || in_valid || string_verdicts.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("utf8_stream_validator regression: pass");
    end else begin
      $display("utf8_stream_validator regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("utf8_stream_validator regression: fail");
    $finish;
  end

endmodule
